/* design/tsd_pkg.sv */
// Package for the tar stream deframer: constants, phase and kind codes,
// and the result record passed from the parser to the output stage.
// Depends on nothing.
package tsd_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int OFF_W = $clog2(BLOCK_BYTES);
	localparam int SIZE_W = 36;
	localparam int USUM_W = 18;
	localparam int SSUM_W = 19;
	localparam int REF_W = 24;

	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(BLOCK_BYTES - 1);
	localparam logic [OFF_W-1:0] NAME_BYTES = OFF_W'(100);
	localparam logic [OFF_W-1:0] SIZE_FIRST = OFF_W'(124);
	localparam logic [OFF_W-1:0] SIZE_LAST = OFF_W'(135);
	localparam logic [OFF_W-1:0] SUM_FIRST = OFF_W'(148);
	localparam logic [OFF_W-1:0] SUM_LAST = OFF_W'(155);
	localparam logic [OFF_W-1:0] TYPE_OFF = OFF_W'(156);

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_SEVEN = 8'h37;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_EOA,
		PH_DATA,
		PH_SKIP,
		PH_PAD,
		PH_DONE,
		PH_ERROR
	} phase_t;

	typedef enum logic [2:0] {
		K_NAME,
		K_START,
		K_SKIPPED,
		K_DATA,
		K_END,
		K_ERROR
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [7:0]        byte_value;
		logic [SIZE_W-1:0] file_size;
		logic              last_of_file;
	} result_t;

endpackage

/* design/tsd_in_stage.sv */
// Input register of the tar stream deframer: holds one archive byte
// until the parser consumes it. Depends on nothing.
module tsd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] archive_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= archive_byte;
		end
	end

endmodule

/* design/tsd_parser.sv */
// Header, payload and padding parser of the tar stream deframer.
// Holds the parse state and forms at most one result per byte.
// Depends on tsd_pkg.
module tsd_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [7:0]       byte_s1,
	output tsd_pkg::result_t result
);

	tsd_pkg::phase_t phase_q, phase_d;
	logic [tsd_pkg::OFF_W-1:0] off_q, off_d;
	logic [tsd_pkg::USUM_W-1:0] usum_q, usum_d, usum_add;
	logic [tsd_pkg::SSUM_W-1:0] ssum_q, ssum_d, ssum_add;
	logic [tsd_pkg::REF_W-1:0] ref_q, ref_d;
	logic [tsd_pkg::SIZE_W-1:0] size_q, size_d;
	logic [7:0] type_q, type_d;
	logic nz_q, nz_d;
	logic named_q, named_d;
	logic [tsd_pkg::SIZE_W-1:0] left_q, left_d, left_dec;
	logic [tsd_pkg::OFF_W-1:0] pad_q, pad_d, pad_dec;
	logic [7:0] counted;
	logic in_sum, in_size, octal, sum_ok;

	always_comb begin
		in_sum = off_q >= tsd_pkg::SUM_FIRST && off_q <= tsd_pkg::SUM_LAST;
		in_size = off_q >= tsd_pkg::SIZE_FIRST && off_q <= tsd_pkg::SIZE_LAST;
		octal = byte_s1 >= tsd_pkg::CHAR_ZERO && byte_s1 <= tsd_pkg::CHAR_SEVEN;
		counted = in_sum ? tsd_pkg::CHAR_SPACE : byte_s1;
		usum_add = usum_q + {{(tsd_pkg::USUM_W-8){1'b0}}, counted};
		ssum_add = ssum_q + {{(tsd_pkg::SSUM_W-8){counted[7]}}, counted};
		sum_ok = (ref_q == {{(tsd_pkg::REF_W-tsd_pkg::USUM_W){1'b0}}, usum_add})
			|| (!ssum_add[tsd_pkg::SSUM_W-1]
			&& ref_q == {{(tsd_pkg::REF_W-tsd_pkg::SSUM_W){1'b0}}, ssum_add});
		left_dec = left_q - tsd_pkg::SIZE_W'(1);
		pad_dec = pad_q - tsd_pkg::OFF_W'(1);

		phase_d = phase_q;
		off_d = off_q;
		usum_d = usum_q;
		ssum_d = ssum_q;
		ref_d = ref_q;
		size_d = size_q;
		type_d = type_q;
		nz_d = nz_q;
		named_d = named_q;
		left_d = left_q;
		pad_d = pad_q;
		result = '0;

		if (advance) begin
			case (phase_q)
				tsd_pkg::PH_HEADER: begin
					usum_d = usum_add;
					ssum_d = ssum_add;
					if (byte_s1 != 8'd0) begin
						nz_d = 1'b1;
					end
					if (off_q < tsd_pkg::NAME_BYTES && !named_q) begin
						if (byte_s1 == 8'd0) begin
							named_d = 1'b1;
						end else begin
							result.valid = 1'b1;
							result.kind = tsd_pkg::K_NAME;
							result.byte_value = byte_s1;
						end
					end
					if (in_size && octal) begin
						size_d = {size_q[tsd_pkg::SIZE_W-4:0], byte_s1[2:0]};
					end
					if (in_sum && octal) begin
						ref_d = {ref_q[tsd_pkg::REF_W-4:0], byte_s1[2:0]};
					end
					if (off_q == tsd_pkg::TYPE_OFF) begin
						type_d = byte_s1;
					end
					if (off_q != tsd_pkg::OFF_LAST) begin
						off_d = off_q + tsd_pkg::OFF_W'(1);
					end else begin
						off_d = '0;
						usum_d = '0;
						ssum_d = '0;
						ref_d = '0;
						size_d = '0;
						type_d = '0;
						nz_d = 1'b0;
						named_d = 1'b0;
						if (!(nz_q || byte_s1 != 8'd0)) begin
							phase_d = tsd_pkg::PH_EOA;
						end else if (!sum_ok) begin
							phase_d = tsd_pkg::PH_ERROR;
							result.valid = 1'b1;
							result.kind = tsd_pkg::K_ERROR;
						end else begin
							result.valid = 1'b1;
							left_d = size_q;
							pad_d = tsd_pkg::OFF_W'(-size_q[tsd_pkg::OFF_W-1:0]);
							if (type_q == tsd_pkg::CHAR_ZERO || type_q == 8'd0) begin
								result.kind = tsd_pkg::K_START;
								result.file_size = size_q;
								result.last_of_file = (size_q == '0);
								phase_d = (size_q != '0) ? tsd_pkg::PH_DATA
									: tsd_pkg::PH_HEADER;
							end else begin
								result.kind = tsd_pkg::K_SKIPPED;
								phase_d = (size_q != '0) ? tsd_pkg::PH_SKIP
									: tsd_pkg::PH_HEADER;
							end
						end
					end
				end
				tsd_pkg::PH_EOA: begin
					if (off_q != tsd_pkg::OFF_LAST) begin
						off_d = off_q + tsd_pkg::OFF_W'(1);
					end else begin
						off_d = '0;
						phase_d = tsd_pkg::PH_DONE;
						result.valid = 1'b1;
						result.kind = tsd_pkg::K_END;
					end
				end
				tsd_pkg::PH_DATA, tsd_pkg::PH_SKIP: begin
					left_d = left_dec;
					if (phase_q == tsd_pkg::PH_DATA) begin
						result.valid = 1'b1;
						result.kind = tsd_pkg::K_DATA;
						result.byte_value = byte_s1;
						result.last_of_file = (left_dec == '0);
					end
					if (left_dec == '0) begin
						phase_d = (pad_q != '0) ? tsd_pkg::PH_PAD : tsd_pkg::PH_HEADER;
					end
				end
				tsd_pkg::PH_PAD: begin
					pad_d = pad_dec;
					if (pad_dec == '0) begin
						phase_d = tsd_pkg::PH_HEADER;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tsd_pkg::PH_HEADER;
			off_q <= '0;
			usum_q <= '0;
			ssum_q <= '0;
			ref_q <= '0;
			size_q <= '0;
			type_q <= '0;
			nz_q <= 1'b0;
			named_q <= 1'b0;
			left_q <= '0;
			pad_q <= '0;
		end else begin
			phase_q <= phase_d;
			off_q <= off_d;
			usum_q <= usum_d;
			ssum_q <= ssum_d;
			ref_q <= ref_d;
			size_q <= size_d;
			type_q <= type_d;
			nz_q <= nz_d;
			named_q <= named_d;
			left_q <= left_d;
			pad_q <= pad_d;
		end
	end

endmodule

/* design/tsd_out_stage.sv */
// Output register of the tar stream deframer: holds one result item
// until the consumer takes it. Depends on tsd_pkg.
module tsd_out_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  tsd_pkg::result_t            result,
	output logic                        free,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  kind,
	output logic [7:0]                  byte_value,
	output logic [tsd_pkg::SIZE_W-1:0]  file_size,
	output logic                        last_of_file
);

	logic load;

	assign free = !out_valid || out_ready;
	assign load = advance && result.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind <= result.kind;
			byte_value <= result.byte_value;
			file_size <= result.file_size;
			last_of_file <= result.last_of_file;
		end
	end

endmodule

/* design/tar_stream_deframer.sv */
// Tar stream deframer: reads a ustar archive one byte per item and
// reports name bytes, file starts, data bytes, skips, end and errors.
// Each byte is held in the input register; its result item, if any, is registered in the output register.
// Throughput is one byte per cycle; a held result item stalls the input.
// Asynchronous active-low reset returns the parser to the header phase.
// Depends on tsd_pkg, tsd_in_stage, tsd_parser and tsd_out_stage.
module tar_stream_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  archive_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [7:0]  byte_value,
	output logic [35:0] file_size,
	output logic        last_of_file
);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;
	logic free;
	tsd_pkg::result_t result;

	assign advance = valid_s1 && free;

	tsd_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.archive_byte(archive_byte),
		.advance(advance),
		.valid_s1(valid_s1),
		.byte_s1(byte_s1)
	);

	tsd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.byte_s1(byte_s1),
		.result(result)
	);

	tsd_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.advance(advance),
		.result(result),
		.free(free),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.byte_value(byte_value),
		.file_size(file_size),
		.last_of_file(last_of_file)
	);

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && !out_ready |-> !in_ready)
		else $error("input taken while the pipeline is stalled");

	a_start_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tsd_pkg::K_START |-> last_of_file == (file_size == '0))
		else $error("file start last flag disagrees with size");

	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != tsd_pkg::K_NAME && kind != tsd_pkg::K_DATA
		|-> byte_value == 8'd0)
		else $error("byte value set on a control item");

endmodule
